// File: hw/rtl/dfsq_pkg.sv
package dfsq_pkg;

  localparam int DEPTH = 16;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [7:0] EMPTY_MARK = 8'd45;  // '-'

  typedef enum logic {
    ACT_ENQ = 1'b0,
    ACT_DEQ = 1'b1
  } dfsq_action_t;

  typedef enum logic {
    Q_A = 1'b0,
    Q_B = 1'b1
  } dfsq_queue_t;

  // per-queue control from the arbiter
  typedef struct packed {
    logic push;
    logic pop;
  } dfsq_ctl_t;

endpackage

// File: hw/rtl/dual_fifo_shortest_queue_balancer.sv
// Two byte FIFOs (A and B, DEPTH entries each) behind one input channel.
// Input item: action (0 enqueue, 1 dequeue) and data_in. An enqueue goes to
// the shorter queue, ties to A; if that queue is full the byte is dropped and
// dropped is set. A dequeue reads the longer queue, ties to B; if only one
// queue holds data it is read; if both are empty data_out is '-' and
// data_valid is low. Every input item gives exactly one result item, which
// carries both counts after the item.
// out_valid rises in the cycle after acceptance. Throughput: one item per
// cycle while results are taken, set by the single result register; queue
// selection, FIFO update and head read all happen in the accepting cycle.
// in_ready is high while the result register is empty or being taken, so a
// stalled receiver holds the result and stops input until it is taken.
// Reset (rst, synchronous) empties both queues and clears out_valid; the
// FIFO storage itself is not cleared.
module dual_fifo_shortest_queue_balancer
  import dfsq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             action,
  input  logic [7:0]       data_in,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       data_out,
  output logic             data_valid,
  output logic             served_queue,
  output logic             dropped,
  output logic [CNT_W-1:0] count_a,
  output logic [CNT_W-1:0] count_b
);

  dfsq_ctl_t        ctl_a, ctl_b;
  logic [7:0]       head_a, head_b;
  logic [CNT_W-1:0] fill_a, fill_b;
  logic [CNT_W-1:0] fill_a_next, fill_b_next;

  logic             accept;
  logic [7:0]       dout_next;
  logic             valid_next;
  logic             which_next;
  logic             drop_next;
  logic             full_pick;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  dfsq_fifo u_fifo_a (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl_a),
    .din        (data_in),
    .head       (head_a),
    .count      (fill_a),
    .count_next (fill_a_next)
  );

  dfsq_fifo u_fifo_b (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl_b),
    .din        (data_in),
    .head       (head_b),
    .count      (fill_b),
    .count_next (fill_b_next)
  );

  always_comb begin
    ctl_a      = '0;
    ctl_b      = '0;
    dout_next  = EMPTY_MARK;
    valid_next = 1'b0;
    which_next = Q_A;
    drop_next  = 1'b0;
    full_pick  = 1'b0;
    unique case (dfsq_action_t'(action))
      ACT_ENQ: begin
        which_next = (fill_a <= fill_b) ? Q_A : Q_B;
        full_pick  = (which_next == Q_A) ? (fill_a == CNT_W'(DEPTH))
                                         : (fill_b == CNT_W'(DEPTH));
        drop_next  = full_pick;
        ctl_a.push = accept && !full_pick && (which_next == Q_A);
        ctl_b.push = accept && !full_pick && (which_next == Q_B);
      end
      ACT_DEQ: begin
        priority if (fill_a != '0 && fill_b != '0) begin
          which_next = (fill_a <= fill_b) ? Q_B : Q_A;
          valid_next = 1'b1;
        end else if (fill_a != '0) begin
          which_next = Q_A;
          valid_next = 1'b1;
        end else if (fill_b != '0) begin
          which_next = Q_B;
          valid_next = 1'b1;
        end else begin
          which_next = Q_A;
        end
        if (valid_next) begin
          dout_next = (which_next == Q_A) ? head_a : head_b;
        end
        ctl_a.pop = accept && valid_next && (which_next == Q_A);
        ctl_b.pop = accept && valid_next && (which_next == Q_B);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_out     <= dout_next;
      data_valid   <= valid_next;
      served_queue <= which_next;
      dropped      <= drop_next;
      count_a      <= fill_a_next;
      count_b      <= fill_b_next;
    end
  end

endmodule

// File: hw/rtl/dfsq_fifo.sv
module dfsq_fifo
  import dfsq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  dfsq_ctl_t        ctl,
  input  logic [7:0]       din,
  output logic [7:0]       head,
  output logic [CNT_W-1:0] count,
  output logic [CNT_W-1:0] count_next
);

  logic [7:0]       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] rd_ptr_next;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  assign rd_ptr_next = ctl.pop ? ptr_inc(rd_ptr) : rd_ptr;

  // arbiter never pushes a full queue or pops an empty one, and never both at once
  always_comb begin
    count_next = count;
    if (ctl.push) begin
      count_next = count + CNT_W'(1);
    end else if (ctl.pop) begin
      count_next = count - CNT_W'(1);
    end
  end

  // head register tracks the entry at the next read pointer; a push into an
  // empty queue lands at that slot, so it is forwarded straight to head
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_ptr] <= din;
    end
    if (ctl.push && wr_ptr == rd_ptr_next) begin
      head <= din;
    end else begin
      head <= mem[rd_ptr_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (ctl.push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (ctl.pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
    end
  end

endmodule

// File: hw/rtl/dfsq_checker.sv
module dfsq_checker
  import dfsq_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input logic [7:0]       data_out,
  input logic             data_valid,
  input logic             served_queue,
  input logic             dropped,
  input logic [CNT_W-1:0] count_a,
  input logic [CNT_W-1:0] count_b
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("out_valid high after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data_out) && $stable(count_a)
      && $stable(count_b) && $stable(data_valid))
    else $error("stalled result changed");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> count_a <= CNT_W'(DEPTH) && count_b <= CNT_W'(DEPTH))
    else $error("count beyond depth");

  // a drop only happens on the full queue it names
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && dropped |-> !data_valid
      && ((served_queue == Q_A && count_a == CNT_W'(DEPTH))
       || (served_queue == Q_B && count_b == CNT_W'(DEPTH))))
    else $error("drop without full queue");

  a_empty_mark: assert property (@(posedge clk) disable iff (rst)
    out_valid && !data_valid |-> data_out == EMPTY_MARK)
    else $error("no-data result without empty mark");

endmodule

bind dual_fifo_shortest_queue_balancer dfsq_checker u_dfsq_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .data_out     (data_out),
  .data_valid   (data_valid),
  .served_queue (served_queue),
  .dropped      (dropped),
  .count_a      (count_a),
  .count_b      (count_b)
);
